FILE: rtl/core/hkv_pkg.sv
// Package for the hashed key-value table.
// Holds the operation and status codes and word widths shared by three modules.
// No dependencies.
package hkv_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_HIT  = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

FILE: rtl/core/hash_key_value_table.sv
// Top level of the hashed key-value table: sequencer, slot compare and table memories.
// Depends on hkv_pkg, hkv_ram and hkv_mod_unit.
//
// Usage: each input word on the in_ channel is one operation (insert or overwrite,
// get, remove) on a 32-bit key, with a 32-bit value for insert. Each input word
// yields exactly one result word on the out_ channel: a status (hit, miss, full)
// and the old, read or removed value on a hit, zero otherwise.
// The block handles one operation at a time. After acceptance the bucket index
// is computed, by a mask when BUCKET_COUNT is a power of two and by a reciprocal
// multiplication otherwise. The slots of the bucket are then read and compared one
// at a time through the shared key comparator, stopping at the first hit, and a
// final step applies the update and loads the output register.
// The result sits in an output register; the next word is accepted while it waits,
// but the update cycle of that next word waits until the output register is free.
// After reset the slot valid bits are cleared by a pass over the bucket rows, one
// row per cycle, during which in_ready stays low.
module hash_key_value_table #(
  parameter int BUCKET_COUNT     = 256,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hkv_pkg::OP_W-1:0]   in_operation,
  input  logic [hkv_pkg::WORD_W-1:0] in_key,
  input  logic [hkv_pkg::WORD_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hkv_pkg::ST_W-1:0]   out_status,
  output logic [hkv_pkg::WORD_W-1:0] out_result_value
);
  import hkv_pkg::*;

  localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int ADDR_W = BKT_W + SLOT_W;
  localparam int KV_DEPTH = 2 ** ADDR_W;
  localparam logic [BKT_W-1:0]  LAST_ROW  = BKT_W'(BUCKET_COUNT - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_BUCKET - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_CMP   = 6'b010000,
    S_ACT   = 6'b100000
  } state_t;

  typedef logic [SLOTS_PER_BUCKET-1:0] row_t;

  state_t              state_r, state_nxt;
  logic [BKT_W-1:0]    clr_r, clr_nxt;
  logic [OP_W-1:0]     op_r;
  logic [WORD_W-1:0]   key_r;
  logic [WORD_W-1:0]   val_r;
  logic [BKT_W-1:0]    bkt_r, bkt_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  row_t                vrow_r, vrow_nxt;
  logic                hit_r, hit_nxt;
  logic [SLOT_W-1:0]   hit_slot_r, hit_slot_nxt;
  logic [WORD_W-1:0]   hitval_r, hitval_nxt;
  logic                free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]   free_slot_r, free_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]     out_status_r, out_status_nxt;
  logic [WORD_W-1:0]   out_value_r, out_value_nxt;

  logic                accept;
  logic                mod_done;
  logic [BKT_W-1:0]    mod_bucket;
  logic                cur_hit;

  logic                v_we, v_re;
  logic [BKT_W-1:0]    v_waddr;
  row_t                v_wdata, v_rdata;
  logic                k_we, val_we, kv_re;
  logic [ADDR_W-1:0]   kv_waddr, kv_raddr;
  logic [WORD_W-1:0]   k_rdata, val_rdata, val_wdata;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  hkv_mod_unit #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_key),
    .done  (mod_done),
    .bucket(mod_bucket)
  );

  hkv_ram #(
    .WIDTH(SLOTS_PER_BUCKET),
    .DEPTH(BUCKET_COUNT)
  ) u_valid_ram (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata(v_wdata),
    .re   (v_re),
    .raddr(bkt_r),
    .rdata(v_rdata)
  );

  hkv_ram #(
    .WIDTH(WORD_W),
    .DEPTH(KV_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (k_we),
    .waddr(kv_waddr),
    .wdata(key_r),
    .re   (kv_re),
    .raddr(kv_raddr),
    .rdata(k_rdata)
  );

  hkv_ram #(
    .WIDTH(WORD_W),
    .DEPTH(KV_DEPTH)
  ) u_value_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(kv_waddr),
    .wdata(val_wdata),
    .re   (kv_re),
    .raddr(kv_raddr),
    .rdata(val_rdata)
  );

  assign kv_raddr  = {bkt_r, slot_r};
  assign val_wdata = val_r;
  assign cur_hit   = v_rdata[slot_r] && (k_rdata == key_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    bkt_nxt        = bkt_r;
    slot_nxt       = slot_r;
    vrow_nxt       = vrow_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hitval_nxt     = hitval_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    v_we           = 1'b0;
    v_re           = 1'b0;
    v_waddr        = bkt_r;
    v_wdata        = vrow_r;
    k_we           = 1'b0;
    val_we         = 1'b0;
    kv_re          = 1'b0;
    kv_waddr       = {bkt_r, hit_slot_r};

    unique case (state_r)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_r;
        v_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          bkt_nxt        = mod_bucket;
          slot_nxt       = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        v_re      = 1'b1;
        kv_re     = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        vrow_nxt = v_rdata;
        if (cur_hit) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = slot_r;
          hitval_nxt   = val_rdata;
          state_nxt    = S_ACT;
        end else begin
          if (!v_rdata[slot_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = slot_r;
          end
          if (slot_r == LAST_SLOT) begin
            state_nxt = S_ACT;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_ACT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISS;
          out_value_nxt  = '0;
          state_nxt      = S_IDLE;
          unique case (op_r)
            OP_INSERT: begin
              if (hit_r) begin
                val_we         = 1'b1;
                out_status_nxt = ST_HIT;
                out_value_nxt  = hitval_r;
              end else if (free_found_r) begin
                kv_waddr = {bkt_r, free_slot_r};
                k_we     = 1'b1;
                val_we   = 1'b1;
                v_we     = 1'b1;
                v_wdata  = vrow_r | (row_t'(1) << free_slot_r);
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_GET: begin
              if (hit_r) begin
                out_status_nxt = ST_HIT;
                out_value_nxt  = hitval_r;
              end
            end
            OP_REMOVE: begin
              if (hit_r) begin
                v_we           = 1'b1;
                v_wdata        = vrow_r & ~(row_t'(1) << hit_slot_r);
                out_status_nxt = ST_HIT;
                out_value_nxt  = hitval_r;
              end
            end
            default: begin
              out_status_nxt = ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
    bkt_r        <= bkt_nxt;
    slot_r       <= slot_nxt;
    vrow_r       <= vrow_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hitval_r     <= hitval_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

endmodule

FILE: rtl/core/hkv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/hkv_mod_unit.sv
// Bucket index unit: key modulo the bucket count.
// A power-of-two count is a mask; any other count uses a reciprocal multiplication.
// Depends on hkv_pkg.
module hkv_mod_unit #(
  parameter int BUCKET_COUNT = 256,
  localparam int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hkv_pkg::WORD_W-1:0] key,
  output logic                       done,
  output logic [BKT_W-1:0]           bucket
);
  import hkv_pkg::*;

  localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      localparam logic [WORD_W-1:0] KEY_MASK = WORD_W'(BUCKET_COUNT - 1);
      logic             done_r;
      logic [BKT_W-1:0] bucket_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          bucket_r <= BKT_W'(key & KEY_MASK);
        end
      end

      assign done   = done_r;
      assign bucket = bucket_r;
    end else begin : g_recip
      localparam int SHIFT = $clog2(BUCKET_COUNT);
      localparam logic [2*WORD_W-1:0] DIV_WIDE = (2*WORD_W)'(BUCKET_COUNT);
      localparam logic [2*WORD_W-1:0] RECIP_WIDE =
        (((2*WORD_W)'(1) << WORD_W) * (((2*WORD_W)'(1) << SHIFT) - DIV_WIDE)) / DIV_WIDE
        + (2*WORD_W)'(1);
      localparam logic [WORD_W-1:0] RECIP   = WORD_W'(RECIP_WIDE);
      localparam logic [WORD_W-1:0] DIVISOR = WORD_W'(BUCKET_COUNT);
      logic                stg1_r;
      logic                stg2_r;
      logic                stg3_r;
      logic                done_r;
      logic [WORD_W-1:0]   key_r;
      logic [WORD_W-1:0]   prod_hi_r;
      logic [WORD_W-1:0]   quot_r;
      logic [BKT_W-1:0]    rem_r;
      logic [2*WORD_W-1:0] prod;
      logic [WORD_W-1:0]   half_diff;
      logic [WORD_W-1:0]   quot_sum;
      logic [WORD_W-1:0]   quot_nxt;
      logic [WORD_W-1:0]   rem_full;

      // The quotient is exact for every key: high product half plus half the gap, shifted.
      assign prod      = (2*WORD_W)'(key_r) * (2*WORD_W)'(RECIP);
      assign half_diff = (key_r - prod_hi_r) >> 1;
      assign quot_sum  = prod_hi_r + half_diff;
      assign quot_nxt  = quot_sum >> (SHIFT - 1);
      assign rem_full  = key_r - quot_r * DIVISOR;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg1_r <= 1'b0;
          stg2_r <= 1'b0;
          stg3_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          stg1_r <= start;
          stg2_r <= stg1_r;
          stg3_r <= stg2_r;
          done_r <= stg3_r;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          key_r <= key;
        end
        if (stg1_r) begin
          prod_hi_r <= prod[2*WORD_W-1:WORD_W];
        end
        if (stg2_r) begin
          quot_r <= quot_nxt;
        end
        if (stg3_r) begin
          rem_r <= rem_full[BKT_W-1:0];
        end
      end

      assign done   = done_r;
      assign bucket = rem_r;
    end
  endgenerate

endmodule

FILE: dv/tb.sv
// Self-checking testbench for hash_key_value_table: queue-fed driver, monitor and scoreboard.
// Predicts each result word from a local model of the bucket slots and checks it in order.
// Depends on hkv_pkg and the hash_key_value_table RTL.
module tb;
  import hkv_pkg::*;

  localparam int unsigned BUCKET_COUNT     = 256;
  localparam int unsigned SLOTS_PER_BUCKET = 4;
  localparam int unsigned TABLE_DEPTH      = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
  localparam int RANDOM_WORDS = 600;
  localparam int QUIET_LO     = 1500;
  localparam int QUIET_HI     = 3000;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] val;
    bit                drain_first;
  } op_word_t;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [WORD_W-1:0] value;
  } result_word_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = '0;
  logic [WORD_W-1:0] in_key = '0;
  logic [WORD_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [WORD_W-1:0] out_result_value;

  bit tbl_valid [TABLE_DEPTH];
  logic [WORD_W-1:0] tbl_key [TABLE_DEPTH];
  logic [WORD_W-1:0] tbl_value [TABLE_DEPTH];

  op_word_t pending_q[$];
  result_word_t expected_q[$];
  op_word_t cur_word;
  int fail_count = 0;
  int cyc = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [23:0] hi_pool [6];
  logic [7:0] lo_pool [4];

  hash_key_value_table #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_key(in_key),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_result_value(out_result_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic bit side_idles();
    return (cyc < QUIET_LO || cyc >= QUIET_HI) && ($urandom_range(0, 99) < 9);
  endfunction

  function automatic result_word_t table_apply(op_word_t w);
    int unsigned base;
    int hit_idx;
    int free_idx;
    result_word_t r;
    base = (w.key % BUCKET_COUNT) * SLOTS_PER_BUCKET;
    hit_idx = -1;
    free_idx = -1;
    r.status = ST_MISS;
    r.value = '0;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (tbl_valid[base+s] && tbl_key[base+s] == w.key && hit_idx < 0) hit_idx = base + s;
      if (!tbl_valid[base+s] && free_idx < 0) free_idx = base + s;
    end
    case (w.op)
      OP_INSERT: begin
        if (hit_idx >= 0) begin
          r.status = ST_HIT;
          r.value = tbl_value[hit_idx];
          tbl_value[hit_idx] = w.val;
        end else if (free_idx >= 0) begin
          tbl_valid[free_idx] = 1'b1;
          tbl_key[free_idx] = w.key;
          tbl_value[free_idx] = w.val;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_GET: begin
        if (hit_idx >= 0) begin
          r.status = ST_HIT;
          r.value = tbl_value[hit_idx];
        end
      end
      OP_REMOVE: begin
        if (hit_idx >= 0) begin
          r.status = ST_HIT;
          r.value = tbl_value[hit_idx];
          tbl_valid[hit_idx] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic add_word(logic [OP_W-1:0] op, logic [WORD_W-1:0] key,
                          logic [WORD_W-1:0] val, bit drain_first);
    op_word_t w;
    w.op = op;
    w.key = key;
    w.val = val;
    w.drain_first = drain_first;
    pending_q.push_back(w);
  endtask

  always @(posedge clk) begin
    op_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(table_apply(cur_word));
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && !(pending_q[0].drain_first && expected_q.size() != 0)
            && !side_idles()) begin
          nxt = pending_q.pop_front();
          cur_word = nxt;
          in_valid <= 1'b1;
          in_operation <= nxt.op;
          in_key <= nxt.key;
          in_value <= nxt.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_word_t exp_word;
    bit next_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, status %0d value %h", $time,
                   out_status, out_result_value);
          fail_count++;
        end else begin
          exp_word = expected_q.pop_front();
          if (out_status !== exp_word.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_word.status,
                     out_status);
            fail_count++;
          end
          if (out_result_value !== exp_word.value) begin
            $display("%0t: result_value expected %h actual %h", $time, exp_word.value,
                     out_result_value);
            fail_count++;
          end
        end
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = !side_idles();
      end
      out_ready <= next_ready;
    end
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] val;
    int pick;
    for (int i = 0; i < 6; i++) hi_pool[i] = 24'($urandom);
    lo_pool[0] = 8'h00;
    lo_pool[1] = 8'hFF;
    lo_pool[2] = 8'($urandom);
    lo_pool[3] = 8'($urandom);

    add_word(OP_INSERT, 32'h0, 32'h0, 1'b0);
    add_word(OP_GET, 32'h0, $urandom, 1'b0);
    add_word(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_word(OP_GET, 32'h0, 32'h0, 1'b0);
    add_word(OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_word(OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
    add_word(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_word(OP_UNDEF, 32'h0, $urandom, 1'b0);
    add_word(OP_GET, 32'h0, 32'h0, 1'b0);
    add_word(OP_INSERT, 32'h100, 32'hA5A5_0100, 1'b0);
    add_word(OP_INSERT, 32'h200, 32'hA5A5_0200, 1'b0);
    add_word(OP_INSERT, 32'h300, 32'hA5A5_0300, 1'b0);
    add_word(OP_INSERT, 32'h400, 32'hA5A5_0400, 1'b0);
    add_word(OP_GET, 32'h400, 32'h0, 1'b0);
    add_word(OP_REMOVE, 32'h200, 32'h0, 1'b0);
    add_word(OP_INSERT, 32'h400, 32'h5A5A_0400, 1'b0);
    add_word(OP_GET, 32'h400, 32'h0, 1'b0);
    add_word(OP_INSERT, 32'h300, 32'h0, 1'b0);
    add_word(OP_UNDEF, 32'h300, 32'hFFFF_FFFF, 1'b0);
    add_word(OP_REMOVE, 32'h0, 32'h0, 1'b0);
    add_word(OP_GET, 32'h0, 32'h0, 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_INSERT;
      else if (pick < 65) op = OP_GET;
      else if (pick < 93) op = OP_REMOVE;
      else op = OP_UNDEF;
      if ($urandom_range(0, 99) < 20) key = $urandom;
      else key = {hi_pool[$urandom_range(0, 5)], lo_pool[$urandom_range(0, 3)]};
      pick = $urandom_range(0, 99);
      if (pick < 5) val = 32'h0;
      else if (pick < 10) val = 32'hFFFF_FFFF;
      else val = $urandom;
      add_word(op, key, val, n == 0 || n == RANDOM_WORDS / 2);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/hkv_pkg.sv
rtl/core/hkv_ram.sv
rtl/core/hkv_mod_unit.sv
rtl/core/hash_key_value_table.sv
dv/tb.sv
